FILE: src/rcpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpf_pkg
// Shared types and codes for the rectangle collision pair finder.
// ----------------------------------------------------------------------------
package rcpf_pkg;

  // input transaction kinds
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_SCAN   = 2'd2;

  // result kinds
  localparam logic [2:0] RES_ADDED   = 3'd0;
  localparam logic [2:0] RES_FULL    = 3'd1;
  localparam logic [2:0] RES_REMOVED = 3'd2;
  localparam logic [2:0] RES_PAIR    = 3'd3;
  localparam logic [2:0] RES_NOPAIR  = 3'd4;

  localparam logic [63:0] MaskReset  = 64'd146939848027706810;
  localparam logic [5:0]  MaxResults = 6'd63;

  // one slot table entry
  typedef struct packed {
    logic [2:0]         obj_type;
    logic [14:0]        height;
    logic [14:0]        width;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_x;
  } entry_t;

endpackage

FILE: src/rcpf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rcpf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/rect_collision_pair_finder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_collision_pair_finder_unit
// Slot table of typed rectangles: add, remove, and scan one slot against all
// higher occupied slots for strict overlap, filtered by a type pair mask, max 63 pairs.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser: kind; tdata: slot, pos_x,
//                                              pos_y, width, height, obj_type
//  m_axis    out  m_axis_tvalid/m_axis_tready  tuser: result_kind; tdata:
//                                              first_slot, second_slot; tlast
//  cfg       in   cfg_we_i                     cfg_wdata_i: type pair mask
//
//  One transaction is in work at a time; s_axis_tready is high only when idle.
//  Add searches the valid bits one slot per cycle.
//  Scan reads the table RAM one slot per cycle while not stalled, one compare
//  per cycle, set by the single RAM read port.
//  Remove and rejected scans go through the emit state. Reset clears the valid
//  bits at once. A full output register holds the scan at the next pair found.
// ----------------------------------------------------------------------------
module rect_collision_pair_finder_unit #(
  parameter int unsigned NUM_SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // slot, pos_x, pos_y, width, height, obj_type, pad
  input  logic [1:0]  s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // first_slot, second_slot, pad
  output logic [2:0]  m_axis_tuser,  // result_kind
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i
);

  import rcpf_pkg::*;

  localparam int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned KW = SW + 1;
  localparam int unsigned IW = ((SW > 6) ? SW : 6) + 1;
  localparam logic [KW-1:0] NumK   = KW'(NUM_SLOTS);
  localparam logic [KW-1:0] LastK  = KW'(NUM_SLOTS - 1);
  localparam logic [IW-1:0] NumI   = IW'(NUM_SLOTS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ADD    = 3'd1;
  localparam logic [2:0] ST_EMIT   = 3'd2;
  localparam logic [2:0] ST_SCAN_A = 3'd3;
  localparam logic [2:0] ST_SCAN_B = 3'd4;
  localparam logic [2:0] ST_RUN    = 3'd5;
  localparam logic [2:0] ST_END    = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [NUM_SLOTS-1:0] valid_q, valid_d;
  logic [63:0]          mask_q;
  logic [KW-1:0]        k_q, k_d;
  logic [SW-1:0]        cmp_k_q, cmp_k_d;
  logic                 cmp_v_q, cmp_v_d;
  logic [5:0]           slot_q, slot_d;
  logic [2:0]           res_kind_q, res_kind_d;
  entry_t               ent_q, ent_d;
  entry_t               a_q, a_d;
  logic                 pend_v_q, pend_v_d;
  logic [5:0]           pend_k_q, pend_k_d;
  logic [5:0]           n_q, n_d;

  logic                 out_v_q;
  logic [2:0]           out_kind_q;
  logic [5:0]           out_first_q, out_second_q;
  logic                 out_last_q;

  logic                 push;
  logic [2:0]           push_kind;
  logic [5:0]           push_first, push_second;
  logic                 push_last;
  logic                 can_push;

  logic                 ram_we;
  logic [SW-1:0]        ram_waddr, ram_raddr;
  entry_t               ram_rdata;
  logic [$bits(entry_t)-1:0] ram_rdata_raw;

  logic                 accept;
  logic [1:0]           in_kind;
  logic [5:0]           in_slot;
  logic [IW-1:0]        in_slot_ext;
  logic                 in_range;
  entry_t               in_ent;

  logic signed [17:0]   ax_lo, ax_hi, ay_lo, ay_hi, bx_lo, bx_hi, by_lo, by_hi;
  logic                 overlap, type_ok, hit, stall;

  assign can_push      = !out_v_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign in_kind         = s_axis_tuser;
  assign in_slot         = s_axis_tdata[5:0];
  assign in_ent.pos_x    = s_axis_tdata[21:6];
  assign in_ent.pos_y    = s_axis_tdata[37:22];
  assign in_ent.width    = s_axis_tdata[52:38];
  assign in_ent.height   = s_axis_tdata[67:53];
  assign in_ent.obj_type = s_axis_tdata[70:68];
  assign in_slot_ext     = IW'(in_slot);
  assign in_range        = (in_slot_ext < NumI);

  rcpf_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ent_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  // strict overlap of the held rectangle against the one read back
  always_comb begin
    ax_lo = 18'(a_q.pos_x);
    ay_lo = 18'(a_q.pos_y);
    ax_hi = ax_lo + $signed({3'b000, a_q.width});
    ay_hi = ay_lo + $signed({3'b000, a_q.height});
    bx_lo = 18'(ram_rdata.pos_x);
    by_lo = 18'(ram_rdata.pos_y);
    bx_hi = bx_lo + $signed({3'b000, ram_rdata.width});
    by_hi = by_lo + $signed({3'b000, ram_rdata.height});
    overlap = (ax_lo < bx_hi) && (ax_hi > bx_lo) && (ay_lo < by_hi) && (ay_hi > by_lo);
  end

  assign type_ok = mask_q[{a_q.obj_type, ram_rdata.obj_type}];
  assign hit     = cmp_v_q && valid_q[cmp_k_q] && type_ok && overlap;
  assign stall   = (state_q == ST_RUN) && hit && pend_v_q && !can_push;

  always_comb begin
    ram_raddr = k_q[SW-1:0];
    if (state_q == ST_SCAN_A) begin
      ram_raddr = SW'(IW'(slot_q));
    end else if (stall) begin
      ram_raddr = cmp_k_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    k_d         = k_q;
    cmp_k_d     = cmp_k_q;
    cmp_v_d     = cmp_v_q;
    slot_d      = slot_q;
    res_kind_d  = res_kind_q;
    ent_d       = ent_q;
    a_d         = a_q;
    pend_v_d    = pend_v_q;
    pend_k_d    = pend_k_q;
    n_d         = n_q;
    push        = 1'b0;
    push_kind   = RES_NOPAIR;
    push_first  = slot_q;
    push_second = '0;
    push_last   = 1'b1;
    ram_we      = 1'b0;
    ram_waddr   = k_q[SW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          slot_d = in_slot;
          ent_d  = in_ent;
          case (in_kind)
            KIND_ADD: begin
              k_d     = '0;
              state_d = ST_ADD;
            end
            KIND_REMOVE: begin
              if (in_range) begin
                valid_d[SW'(in_slot_ext)] = 1'b0;
              end
              res_kind_d = RES_REMOVED;
              state_d    = ST_EMIT;
            end
            KIND_SCAN: begin
              if (in_range && valid_q[SW'(in_slot_ext)]) begin
                k_d      = KW'(in_slot_ext) + KW'(1);
                cmp_v_d  = 1'b0;
                pend_v_d = 1'b0;
                n_d      = '0;
                state_d  = ST_SCAN_A;
              end else begin
                res_kind_d = RES_NOPAIR;
                state_d    = ST_EMIT;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      // one valid bit per cycle, lowest free slot wins
      ST_ADD: begin
        if (!valid_q[k_q[SW-1:0]]) begin
          if (can_push) begin
            ram_we                = 1'b1;
            valid_d[k_q[SW-1:0]]  = 1'b1;
            push                  = 1'b1;
            push_kind             = RES_ADDED;
            push_first            = 6'(k_q);
            state_d               = ST_IDLE;
          end
        end else if (k_q == LastK) begin
          if (can_push) begin
            push       = 1'b1;
            push_kind  = RES_FULL;
            push_first = '0;
            state_d    = ST_IDLE;
          end
        end else begin
          k_d = k_q + KW'(1);
        end
      end

      ST_EMIT: begin
        if (can_push) begin
          push      = 1'b1;
          push_kind = res_kind_q;
          state_d   = ST_IDLE;
        end
      end

      ST_SCAN_A: begin
        state_d = ST_SCAN_B;
      end

      // capture the scanned slot and issue the first candidate read
      ST_SCAN_B: begin
        a_d     = ram_rdata;
        cmp_k_d = k_q[SW-1:0];
        cmp_v_d = (k_q < NumK);
        if (k_q < NumK) begin
          k_d = k_q + KW'(1);
        end
        state_d = ST_RUN;
      end

      ST_RUN: begin
        if (!stall) begin
          if (hit) begin
            if (pend_v_q) begin
              push        = 1'b1;
              push_kind   = RES_PAIR;
              push_second = pend_k_q;
              push_last   = 1'b0;
            end
            pend_v_d = 1'b1;
            pend_k_d = 6'(cmp_k_q);
            n_d      = n_q + 6'd1;
          end
          if (hit && (n_q == MaxResults - 6'd1)) begin
            cmp_v_d = 1'b0;
            state_d = ST_END;
          end else if (!cmp_v_q && !(k_q < NumK)) begin
            state_d = ST_END;
          end else begin
            cmp_k_d = k_q[SW-1:0];
            cmp_v_d = (k_q < NumK);
            if (k_q < NumK) begin
              k_d = k_q + KW'(1);
            end
          end
        end
      end

      ST_END: begin
        if (can_push) begin
          push = 1'b1;
          if (pend_v_q) begin
            push_kind   = RES_PAIR;
            push_second = pend_k_q;
          end
          pend_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      valid_q  <= '0;
      mask_q   <= MaskReset;
      cmp_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      cmp_v_q  <= cmp_v_d;
      pend_v_q <= pend_v_d;
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
      if (push) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    cmp_k_q    <= cmp_k_d;
    slot_q     <= slot_d;
    res_kind_q <= res_kind_d;
    ent_q      <= ent_d;
    a_q        <= a_d;
    pend_k_q   <= pend_k_d;
    n_q        <= n_d;
    if (push) begin
      out_kind_q   <= push_kind;
      out_first_q  <= push_first;
      out_second_q <= push_second;
      out_last_q   <= push_last;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {4'b0000, out_second_q, out_first_q};
  assign m_axis_tlast  = out_last_q;

endmodule
